/* rtl/core/mul_div_32x16_unit_assert.svh */
// Assertion macros shared by the multiply/divide unit modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef MUL_DIV_32X16_UNIT_ASSERT_SVH
`define MUL_DIV_32X16_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MDU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mul_div_32x16_unit assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MDU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mul_div_32x16_unit assertion failed");

`endif

/* rtl/core/mdu_pkg.sv */
// Package for the 32x16 multiply/divide unit: widths, operation kinds,
// step counts and the control struct between sequencer and datapath.
// No dependencies.
package mdu_pkg;

    localparam int A_W    = 32;
    localparam int B_W    = 16;
    localparam int KIND_W = 2;
    localparam int CNT_W  = 5;

    // Operation kinds carried in tuser.
    localparam logic [KIND_W-1:0] KIND_MUL    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIV    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIVREM = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD   = 2'd3;

    // Last step index for each iterative operation.
    localparam logic [CNT_W-1:0] MUL_LAST = 5'd15;
    localparam logic [CNT_W-1:0] DIV_LAST = 5'd31;

    localparam logic [B_W-1:0] HALF_ONES = 16'hFFFF;

    // Strobes from the sequencer to the datapath and output stage.
    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } mdu_ctrl_t;

endpackage

/* rtl/core/mdu_datapath.sv */
// Bit-serial datapath of the multiply/divide unit: operand and result
// shift registers with one radix-2 step per cycle. Depends on mdu_pkg.
module mdu_datapath
    import mdu_pkg::*;
(
    input  logic              clk,
    input  mdu_ctrl_t         ctrl,
    input  logic [KIND_W-1:0] kind,
    input  logic [A_W-1:0]    operand_a,
    input  logic [B_W-1:0]    operand_b,
    output logic              imm,
    output logic [A_W-1:0]    result,
    output logic [B_W-1:0]    remainder
);

    logic [KIND_W-1:0] kind_reg;
    logic [A_W-1:0]    work_reg;
    logic [A_W-1:0]    mcand_reg;
    logic [B_W-1:0]    opnd_reg;
    logic [B_W-1:0]    rem_reg;

    logic [B_W:0]      trial;
    logic [B_W+1:0]    diff;
    logic              fits;
    logic [A_W-1:0]    addend;

    // Items that finish without iterating: reserved kind, or a divide with remainder
    // whose divisor is zero or whose 16-bit quotient would overflow.
    assign imm = (kind == KIND_RSVD) ||
                 ((kind == KIND_DIVREM) &&
                  ((operand_b == '0) || (operand_a[A_W-1:B_W] >= operand_b)));

    // Restoring division step: shift in the next dividend bit and try the divisor.
    assign trial  = {rem_reg, work_reg[A_W-1]};
    assign diff   = {1'b0, trial} - {2'b00, opnd_reg};
    assign fits   = !diff[B_W+1];

    // Shift-add multiply step, multiplier bits taken from the top down.
    assign addend = opnd_reg[B_W-1] ? mcand_reg : '0;

    // Operand and result shift registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            kind_reg  <= kind;
            mcand_reg <= operand_a;
            opnd_reg  <= operand_b;
            if (kind == KIND_RSVD)
            begin
                work_reg <= '0;
                rem_reg  <= '0;
            end
            else if (imm)
            begin
                work_reg <= {{(A_W-B_W){1'b0}}, HALF_ONES};
                rem_reg  <= HALF_ONES;
            end
            else if (kind == KIND_MUL)
            begin
                work_reg <= '0;
                rem_reg  <= '0;
            end
            else
            begin
                work_reg <= operand_a;
                rem_reg  <= '0;
            end
        end
        else if (ctrl.step)
        begin
            if (kind_reg == KIND_MUL)
            begin
                work_reg <= {work_reg[A_W-2:0], 1'b0} + addend;
                opnd_reg <= {opnd_reg[B_W-2:0], 1'b0};
            end
            else
            begin
                work_reg <= {work_reg[A_W-2:0], fits};
                rem_reg  <= fits ? diff[B_W-1:0] : trial[B_W-1:0];
            end
        end
    end

    assign result    = work_reg;
    assign remainder = (kind_reg == KIND_DIVREM) ? rem_reg : '0;

endmodule

/* rtl/core/mdu_ctrl.sv */
// Sequencer of the multiply/divide unit: input handshake, step counter
// and hand-off to the output register. Depends on mdu_pkg and the assert header.
`include "mul_div_32x16_unit_assert.svh"

module mdu_ctrl
    import mdu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] kind,
    input  logic              imm,
    input  logic              out_free,
    output logic              in_ready,
    output mdu_ctrl_t         ctrl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state, step count and strobes.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ctrl.load     = 1'b0;
        ctrl.step     = 1'b0;
        ctrl.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = imm ? ST_WAIT : ST_RUN;
                    cnt_next   = (kind == KIND_MUL) ? MUL_LAST : DIV_LAST;
                end
            end
            ST_RUN:
            begin
                ctrl.step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Strobes are exclusive, and the sequence runs load, steps, hand-off.
    `MDU_ASSERT_IMP(a_strobe_excl, 1'b1, $onehot0({ctrl.load, ctrl.step, ctrl.out_load}))
    `MDU_ASSERT_NXT(a_load_runs, ctrl.load && !imm, state_reg == ST_RUN)
    `MDU_ASSERT_NXT(a_last_step, (state_reg == ST_RUN) && (cnt_reg == '0), state_reg == ST_WAIT)

endmodule

/* rtl/core/mul_div_32x16_unit.sv */
// Top level of the unsigned 32x16 multiply/divide unit: stream ports,
// sequencer, bit-serial datapath and output register. Depends on mdu_pkg,
// mdu_ctrl, mdu_datapath and the assert header.
// A multiply iterates over its 16 multiplier bits and a divide over its 32 quotient
// bits, one radix-2 step per bit; the reserved kind and a saturating divide with
// remainder skip the steps.
// A new input is taken only after the previous one has passed to the output register.
// The output register lets the next transaction start while a result waits.
// rst_n clears the sequencer and output valid asynchronously.
`include "mul_div_32x16_unit_assert.svh"

module mul_div_32x16_unit
    import mdu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // operand_a [31:0], operand_b [47:32]
    input  logic [1:0]  s_tuser,   // kind [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // result [31:0], remainder [47:32]
);

    mdu_ctrl_t          ctl;
    logic               imm;
    logic               out_free;
    logic [A_W-1:0]     dp_result;
    logic [B_W-1:0]     dp_remainder;
    logic               out_valid_reg;
    logic [A_W+B_W-1:0] out_data_reg;

    assign out_free = !out_valid_reg || m_tready;

    mdu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .kind     (s_tuser),
        .imm      (imm),
        .out_free (out_free),
        .in_ready (s_tready),
        .ctrl     (ctl)
    );

    mdu_datapath u_datapath (
        .clk       (clk),
        .ctrl      (ctl),
        .kind      (s_tuser),
        .operand_a (s_tdata[A_W-1:0]),
        .operand_b (s_tdata[A_W+B_W-1:A_W]),
        .imm       (imm),
        .result    (dp_result),
        .remainder (dp_remainder)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_data_reg <= {dp_remainder, dp_result};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A waiting result is never overwritten, and the unit is busy after a transaction.
    `MDU_ASSERT_IMP(a_no_overwrite, ctl.out_load, out_free)
    `MDU_ASSERT_NXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)
    `MDU_ASSERT_NXT(a_result_shown, ctl.out_load, m_tvalid)

endmodule
